### sv/rqwr_pkg.sv
package rqwr_pkg;

  // Fixed field widths of the two channels.
  localparam int KIND_W    = 2;
  localparam int ID_W      = 8;
  localparam int LEN_OUT_W = 5;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DISP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REM  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch_in;
    logic load_match;
    logic scan_step;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_remove;
    logic empty;
    logic scan_hit;
    logic scan_last;
  } dp_status_t;

endpackage

### sv/rqwr_in_if.sv
interface rqwr_in_if import rqwr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   thread_id;

  modport source (output valid, output kind, output thread_id, input ready);
  modport sink   (input valid, input kind, input thread_id, output ready);
endinterface

### sv/rqwr_out_if.sv
interface rqwr_out_if import rqwr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ID_W-1:0]      dispatched_id;
  logic                 dispatch_valid;
  logic [LEN_OUT_W-1:0] queue_length;
  logic [1:0]           status;

  modport source (output valid, output dispatched_id, output dispatch_valid,
                  output queue_length, output status, input ready);
  modport sink   (input valid, input dispatched_id, input dispatch_valid,
                  input queue_length, input status, output ready);
endinterface

### sv/ready_queue_with_removal_unit.sv
// Ready queue of thread identifiers, first in first out, with delete by value.
// The input channel carries one operation per beat: kind selects enqueue at
// the tail, dispatch of the head, or removal of the entry nearest the tail
// that equals thread_id. Every input beat yields exactly one result beat with
// the dispatched identifier (zero unless a dispatch succeeded), a flag for it,
// the queue length after the operation and a status code (ok, full, empty,
// not found). Failed operations leave the queue untouched.
// Enqueue, dispatch and removal from an empty queue run in two steps: the
// beat is captured, then the queue is updated and the result register is
// loaded. A new beat is taken only once the last one has updated the queue.
// A removal compares all entries at once, then walks the match vector from
// the top slot down one bit a cycle until a hit or the bottom slot, and
// then updates the queue and the result register.
// The result sits in a register; a new input beat is accepted while it waits,
// but the queue update for that beat stalls until the receiver takes the old
// result. Synchronous reset empties the queue and drops any pending result.
module ready_queue_with_removal_unit import rqwr_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input logic        clk,
  input logic        rst_n,
  rqwr_in_if.sink    in_ch,
  rqwr_out_if.source out_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // The controller sequences each operation; the datapath holds the queue.
  rqwr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  rqwr_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_kind            (in_ch.kind),
    .in_thread_id       (in_ch.thread_id),
    .out_dispatched_id  (out_ch.dispatched_id),
    .out_dispatch_valid (out_ch.dispatch_valid),
    .out_queue_length   (out_ch.queue_length),
    .out_status         (out_ch.status)
  );

endmodule

### sv/rqwr_datapath.sv
module rqwr_datapath import rqwr_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           st,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [ID_W-1:0]      in_thread_id,
  output logic [ID_W-1:0]      out_dispatched_id,
  output logic                 out_dispatch_valid,
  output logic [LEN_OUT_W-1:0] out_queue_length,
  output logic [1:0]           out_status
);

  localparam int EW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);

  logic [KIND_W-1:0] kind_r;
  logic [EW-1:0]     id_r;
  logic              found_r;
  logic [IW-1:0]     pos_r;
  logic [IW-1:0]     idx_r;
  logic [QUEUE_DEPTH-1:0] match_r;
  logic [EW-1:0]     entry_r [QUEUE_DEPTH];
  logic [LW-1:0]     length_r;

  logic          full;
  logic          empty;
  logic          do_write;
  logic          do_shift;
  logic [IW-1:0] shift_from;
  logic [LW-1:0] length_nxt;
  status_t       status_nxt;
  logic [ID_W-1:0] head_nxt;
  logic          head_valid_nxt;

  assign full  = (length_r == LW'(QUEUE_DEPTH));
  assign empty = (length_r == '0);

  assign st.is_remove = (kind_r == KIND_REM);
  assign st.empty     = empty;
  assign st.scan_hit  = match_r[QUEUE_DEPTH-1];
  assign st.scan_last = (idx_r == '0);

  // Decide the effect of the pending operation.
  always_comb begin
    do_write       = 1'b0;
    do_shift       = 1'b0;
    shift_from     = pos_r;
    length_nxt     = length_r;
    status_nxt     = ST_OK;
    head_nxt       = '0;
    head_valid_nxt = 1'b0;
    unique case (kind_r)
      KIND_ENQ: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          do_write   = 1'b1;
          length_nxt = length_r + 1'b1;
        end
      end
      KIND_DISP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_shift       = 1'b1;
          shift_from     = '0;
          length_nxt     = length_r - 1'b1;
          head_nxt       = ID_W'(entry_r[0]);
          head_valid_nxt = 1'b1;
        end
      end
      KIND_REM: begin
        if (!found_r) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          do_shift   = 1'b1;
          length_nxt = length_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= in_kind;
      id_r   <= in_thread_id[EW-1:0];
    end
  end

  // The match vector is walked from the top slot downward, so the first hit
  // is the entry nearest the tail.
  always_ff @(posedge clk) begin
    if (cmd.load_match) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        match_r[i] <= (entry_r[i] == id_r) && (LW'(i) < length_r);
      end
      idx_r <= IW'(QUEUE_DEPTH - 1);
    end else if (cmd.scan_step && !match_r[QUEUE_DEPTH-1]) begin
      match_r <= match_r << 1;
      idx_r   <= idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.latch_in) begin
      found_r <= 1'b0;
    end else if (cmd.scan_step && match_r[QUEUE_DEPTH-1]) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && match_r[QUEUE_DEPTH-1]) begin
      pos_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.commit && do_shift && (IW'(i) >= shift_from) && (i < QUEUE_DEPTH - 1)) begin
        entry_r[i] <= entry_r[(i + 1) % QUEUE_DEPTH];
      end else if (cmd.commit && do_write && (LW'(i) == length_r)) begin
        entry_r[i] <= id_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= '0;
    end else if (cmd.commit) begin
      length_r <= length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_dispatched_id  <= head_nxt;
      out_dispatch_valid <= head_valid_nxt;
      out_queue_length   <= LEN_OUT_W'(length_nxt);
      out_status         <= status_nxt;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= LW'(QUEUE_DEPTH))
    else $error("queue length exceeds depth");

  a_disp_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (kind_r == KIND_DISP) && !empty |=> length_r == $past(length_r) - 1'b1)
    else $error("dispatch did not shorten the queue");

  a_commit_valid_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_dispatch_valid == (out_status == ST_OK && $past(kind_r) == KIND_DISP)))
    else $error("dispatch flag disagrees with status");

endmodule

### sv/rqwr_ctrl.sv
module rqwr_ctrl import rqwr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (st.is_remove && !st.empty) begin
          state_nxt = S_SCAN;
        end else if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: if (st.scan_hit || st.scan_last) state_nxt = S_FIN;
      S_FIN:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.latch_in   = 1'b0;
    cmd.load_match = 1'b0;
    cmd.scan_step  = 1'b0;
    cmd.commit     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_EXEC: begin
        if (st.is_remove && !st.empty) begin
          cmd.load_match = 1'b1;
        end else begin
          cmd.commit = slot_free;
        end
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_FIN:  cmd.commit = slot_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result written over an untaken beat");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_EXEC)
    else $error("accepted beat not executed");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && st.scan_last |=> state_r == S_FIN)
    else $error("scan ran past the bottom slot");

endmodule
